### rtl/diga_pkg.sv
package diga_pkg;

   localparam int IDX_W           = 10;
   localparam int KEY_W           = 32;
   localparam int VAL_W           = 32;
   localparam int CNT_W           = 31;
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0] COUNT_ONE = CNT_W'(1);

   localparam logic KIND_ACC  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // one queued operation, already classified by the front end
   typedef struct packed {
      logic                    is_read;
      logic                    in_range;
      logic [IDX_W-1:0]        idx;
      logic [KEY_W-1:0]        key;
      logic signed [VAL_W-1:0] value;
   } cmd_type;

   // one table slot as held in the RAM
   typedef struct packed {
      logic                    occupied;
      logic [KEY_W-1:0]        key;
      logic [CNT_W-1:0]        count;
      logic signed [VAL_W-1:0] sum;
      logic signed [VAL_W-1:0] vmin;
      logic signed [VAL_W-1:0] vmax;
   } entry_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      entry_type        slot;
   } rsp_type;

endpackage

### rtl/diga_ram.sv
module diga_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/diga_fifo.sv
module diga_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = diga_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == FULL_CNT);
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/diga_front.sv
module diga_front #(
   parameter int TABLE_DEPTH = diga_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [diga_pkg::IDX_W-1:0]     req_group_index,
   input  logic [diga_pkg::KEY_W-1:0]     req_group_key,
   input  logic signed [diga_pkg::VAL_W-1:0] req_value,
   input  logic                           table_ready,
   input  logic                           q_full,
   output logic                           q_push,
   output diga_pkg::cmd_type              q_cmd
);

   logic in_range;
   logic accepted;

   assign in_range  = 32'(req_group_index) < 32'(TABLE_DEPTH);
   assign req_ready = table_ready && !q_full;
   assign accepted  = req_valid && req_ready;

   // rows aimed beyond the table are dropped here; reads always go through
   assign q_push = accepted && ((req_kind == diga_pkg::KIND_READ) || in_range);

   always_comb begin
      q_cmd.is_read  = (req_kind == diga_pkg::KIND_READ);
      q_cmd.in_range = in_range;
      q_cmd.idx      = req_group_index;
      q_cmd.key      = req_group_key;
      q_cmd.value    = req_value;
   end

endmodule

### rtl/diga_back.sv
module diga_back #(
   parameter int TABLE_DEPTH = diga_pkg::TABLE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  diga_pkg::cmd_type    q_cmd,
   output logic                 q_pop,
   output logic                 table_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output diga_pkg::rsp_type    rsp_word
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int EW = $bits(diga_pkg::entry_type);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   diga_pkg::cmd_type    cmd_ff, cmd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   diga_pkg::rsp_type    rsp_ff, rsp_in;

   logic [31:0]          q_idx_wide, cmd_idx_wide;
   logic [AW-1:0]        rd_addr, cmd_addr;
   logic                 rd_en, wr_en;
   logic [AW-1:0]        wr_addr;
   logic [EW-1:0]        wr_data, rd_data;
   diga_pkg::entry_type  cur, upd;
   logic                 rsp_free;

   assign q_idx_wide   = 32'(q_cmd.idx);
   assign cmd_idx_wide = 32'(cmd_ff.idx);
   assign rd_addr      = q_idx_wide[AW-1:0];
   assign cmd_addr     = cmd_idx_wide[AW-1:0];
   assign cur          = diga_pkg::entry_type'(rd_data);
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   assign table_ready = (state_ff != ST_CLEAR);
   assign q_pop       = (state_ff == ST_IDLE) && !q_empty;
   assign rd_en       = q_pop;

   // merge the row into the slot
   always_comb begin
      if (!cur.occupied) begin
         upd.occupied = 1'b1;
         upd.key      = cmd_ff.key;
         upd.count    = diga_pkg::COUNT_ONE;
         upd.sum      = cmd_ff.value;
         upd.vmin     = cmd_ff.value;
         upd.vmax     = cmd_ff.value;
      end else begin
         upd.occupied = 1'b1;
         upd.key      = cur.key;
         upd.count    = (cur.count == diga_pkg::COUNT_MAX) ? cur.count
                                                           : cur.count + diga_pkg::COUNT_ONE;
         upd.sum      = cur.sum + cmd_ff.value;
         upd.vmin     = (cmd_ff.value < cur.vmin) ? cmd_ff.value : cur.vmin;
         upd.vmax     = (cmd_ff.value > cur.vmax) ? cmd_ff.value : cur.vmax;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cmd_addr;
      wr_data = EW'(upd);
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
         end
         ST_EXEC: begin
            wr_en = !cmd_ff.is_read && cmd_ff.in_range;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cmd_in       = cmd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               cmd_in   = q_cmd;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!cmd_ff.is_read) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.idx   = cmd_ff.idx;
               rsp_in.slot  = (cmd_ff.in_range && cur.occupied) ? cur : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   diga_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

### rtl/direct_indexed_group_aggregate_core.sv
// channel | valid / ready      | payload
// req     | req_valid/req_ready | kind, group_index, group_key, value
// rsp     | rsp_valid/rsp_ready | slot_index, occupied, stored_key, row_count, sum, min, max
//
// In the back end each queued word is first read from the table RAM, then
// merged and written back (or loaded into the response register).
// After reset the table is swept to zero, with req_ready low.
// A two-word queue sits between front and back; a held response only stalls
// the back end when another read reaches it.
module direct_indexed_group_aggregate_core #(
   parameter int TABLE_DEPTH = diga_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [diga_pkg::IDX_W-1:0]        req_group_index,
   input  logic [diga_pkg::KEY_W-1:0]        req_group_key,
   input  logic signed [diga_pkg::VAL_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [diga_pkg::IDX_W-1:0]        rsp_slot_index,
   output logic                              rsp_occupied,
   output logic [diga_pkg::KEY_W-1:0]        rsp_stored_key,
   output logic [diga_pkg::CNT_W-1:0]        rsp_row_count,
   output logic signed [diga_pkg::VAL_W-1:0] rsp_value_sum,
   output logic signed [diga_pkg::VAL_W-1:0] rsp_value_min,
   output logic signed [diga_pkg::VAL_W-1:0] rsp_value_max
);

   localparam int CMD_W = $bits(diga_pkg::cmd_type);

   logic              table_ready;
   logic              q_full, q_empty, q_push, q_pop;
   diga_pkg::cmd_type push_cmd, pop_cmd;
   logic [CMD_W-1:0]  pop_bits;
   diga_pkg::rsp_type rsp_word;

   diga_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_group_index (req_group_index),
      .req_group_key   (req_group_key),
      .req_value       (req_value),
      .table_ready     (table_ready),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   diga_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (diga_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (CMD_W'(push_cmd)),
      .pop       (q_pop),
      .pop_data  (pop_bits),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign pop_cmd = diga_pkg::cmd_type'(pop_bits);

   diga_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_cmd       (pop_cmd),
      .q_pop       (q_pop),
      .table_ready (table_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

   assign rsp_slot_index = rsp_word.idx;
   assign rsp_occupied   = rsp_word.slot.occupied;
   assign rsp_stored_key = rsp_word.slot.key;
   assign rsp_row_count  = rsp_word.slot.count;
   assign rsp_value_sum  = rsp_word.slot.sum;
   assign rsp_value_min  = rsp_word.slot.vmin;
   assign rsp_value_max  = rsp_word.slot.vmax;

endmodule
